/* rtl/slope_scaled_shadow_bias_defines.svh */
// ----------------------------------------------------------------------------
// Slope-scaled shadow bias: assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SLOPE_SCALED_SHADOW_BIAS_DEFINES_SVH
`define SLOPE_SCALED_SHADOW_BIAS_DEFINES_SVH

// same-cycle implication
`define SSB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ssb_pkg.sv */
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared types and constants of the slope-scaled shadow bias pipeline.
// ----------------------------------------------------------------------------
package ssb_pkg;

  localparam int unsigned SqStages  = 5;  // clamp/square plus four root stages
  localparam int unsigned DvStages  = 4;
  localparam int unsigned MulStages = 6;
  localparam int unsigned NumStages = SqStages + DvStages + MulStages;

  localparam logic [15:0] SlopeScaleRst   = 16'd256;
  localparam logic [15:0] ConstTexelsRst  = 16'd0;
  localparam logic [15:0] NormalTexelsRst = 16'd0;
  localparam logic [15:0] MaxTangentRst   = 16'd2560;

  typedef enum logic [1:0] {
    REG_SLOPE_SCALE     = 2'd0,
    REG_CONST_TEXELS    = 2'd1,
    REG_NORMAL_TEXELS   = 2'd2,
    REG_MAX_TANGENT     = 2'd3
  } cfg_idx_e;

  // fragment fields that ride along the pipeline
  typedef struct packed {
    logic [31:0] w;
    logic [31:0] d;
    logic [16:0] f;
    logic        z;   // zero texel or depth scale
  } side_t;

  typedef struct packed {
    side_t       sd;
    logic [14:0] c;
    logic [29:0] v;     // radicand, consumed two bits at a time from the top
    logic [15:0] rem;
    logic [14:0] root;
  } sq_t;

  typedef struct packed {
    side_t       sd;
    logic [14:0] s;
    logic [14:0] c;
    logic        lim;   // quotient at or above 2^16, or zero cosine
    logic [15:0] rem;
    logic [15:0] num;
    logic [15:0] q;
  } dv_t;

  typedef struct packed {
    logic [15:0] slope_scale;
    logic [15:0] const_texels;
    logic [15:0] normal_texels;
    logic [15:0] max_tangent;
  } cfg_t;

endpackage

/* rtl/ssb_sqrt.sv */
// ----------------------------------------------------------------------------
// ssb_sqrt
// Cosine clamp, sine = isqrt(2^28 - c^2), 4 bits per stage, 3 in the last.
// ----------------------------------------------------------------------------
module ssb_sqrt (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [15:0]  n_dot_l_i,
  input  ssb_pkg::side_t      side_i,
  output ssb_pkg::sq_t        sq_o
);

  localparam int unsigned RootStages = ssb_pkg::SqStages - 1;

  ssb_pkg::sq_t chain_q [RootStages+1];
  ssb_pkg::sq_t first_d;

  always_comb begin
    logic [14:0] c;
    logic [29:0] cc;
    if (n_dot_l_i[15]) begin
      c = 15'd0;
    end else if (n_dot_l_i[14:0] > 15'd16384) begin
      c = 15'd16384;
    end else begin
      c = n_dot_l_i[14:0];
    end
    cc = 30'(c) * 30'(c);
    first_d.sd   = side_i;
    first_d.c    = c;
    first_d.v    = 30'h1000_0000 - cc;
    first_d.rem  = 16'd0;
    first_d.root = 15'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chain_q[0] <= first_d;
    end
  end

  for (genvar k = 1; k <= RootStages; k++) begin : g_root
    localparam int unsigned Steps = (k == RootStages) ? 3 : 4;
    ssb_pkg::sq_t x_d;

    always_comb begin
      logic [17:0] r;
      logic [16:0] trial;
      logic [17:0] diff;
      x_d = chain_q[k-1];
      for (int j = 0; j < Steps; j++) begin
        r     = {x_d.rem, x_d.v[29:28]};
        trial = {x_d.root, 2'b01};
        diff  = r - {1'b0, trial};
        if (r >= {1'b0, trial}) begin
          x_d.rem  = diff[15:0];
          x_d.root = {x_d.root[13:0], 1'b1};
        end else begin
          x_d.rem  = r[15:0];
          x_d.root = {x_d.root[13:0], 1'b0};
        end
        x_d.v = {x_d.v[27:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        chain_q[k] <= x_d;
      end
    end
  end

  assign sq_o = chain_q[RootStages];

endmodule

/* rtl/ssb_div.sv */
// ----------------------------------------------------------------------------
// ssb_div
// Tangent quotient floor(s*256/c), restoring, four bits per stage.
// ----------------------------------------------------------------------------
module ssb_div (
  input  logic          clk_i,
  input  logic          en_i,
  input  ssb_pkg::sq_t  sq_i,
  output ssb_pkg::dv_t  dv_o
);

  localparam int unsigned Steps = 4;

  ssb_pkg::dv_t chain_q [ssb_pkg::DvStages];

  for (genvar k = 0; k < ssb_pkg::DvStages; k++) begin : g_div
    ssb_pkg::dv_t x_d;

    always_comb begin
      logic [15:0] r;
      if (k == 0) begin
        x_d.sd  = sq_i.sd;
        x_d.s   = sq_i.root;
        x_d.c   = sq_i.c;
        // also true at zero cosine
        x_d.lim = {8'd0, sq_i.root} >= {sq_i.c, 8'd0};
        x_d.rem = {9'd0, sq_i.root[14:8]};
        x_d.num = {sq_i.root[7:0], 8'd0};
        x_d.q   = 16'd0;
      end else begin
        x_d = chain_q[(k > 0) ? k-1 : 0];
      end
      for (int j = 0; j < Steps; j++) begin
        r = {x_d.rem[14:0], x_d.num[15]};
        if (r >= {1'b0, x_d.c}) begin
          x_d.rem = r - {1'b0, x_d.c};
          x_d.q   = {x_d.q[14:0], 1'b1};
        end else begin
          x_d.rem = r;
          x_d.q   = {x_d.q[14:0], 1'b0};
        end
        x_d.num = {x_d.num[14:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        chain_q[k] <= x_d;
      end
    end
  end

  assign dv_o = chain_q[ssb_pkg::DvStages-1];

endmodule

/* rtl/ssb_mul.sv */
// ----------------------------------------------------------------------------
// ssb_mul
// Gain products, split 32-bit multiplies, bias sum and saturation.
// ----------------------------------------------------------------------------
module ssb_mul (
  input  logic          clk_i,
  input  logic          en_i,
  input  ssb_pkg::dv_t  dv_i,
  input  ssb_pkg::cfg_t cfg_i,
  output logic [31:0]   receiver_depth_bias_o,
  output logic [31:0]   normal_offset_world_o
);

  // stage A: tangent clamp, footprint gains
  ssb_pkg::side_t a_sd_q;
  logic [14:0]    a_s_q;
  logic [15:0]    a_t_q;
  logic [32:0]    a_fs_q, a_fn_q;
  logic [47:0]    a_cw_q;
  logic [15:0]    t_d;

  always_comb begin
    if (dv_i.lim || (dv_i.q >= cfg_i.max_tangent)) begin
      t_d = cfg_i.max_tangent;
    end else begin
      t_d = dv_i.q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_sd_q <= dv_i.sd;
      a_s_q  <= dv_i.s;
      a_t_q  <= t_d;
      a_fs_q <= 33'(dv_i.sd.f) * 33'(cfg_i.slope_scale);
      a_fn_q <= 33'(dv_i.sd.f) * 33'(cfg_i.normal_texels);
      a_cw_q <= 48'(dv_i.sd.w) * 48'(cfg_i.const_texels);
    end
  end

  // stage B: k = F*slope*t, m = F*normal*s
  ssb_pkg::side_t b_sd_q;
  logic [48:0]    b_k_q;
  logic [47:0]    b_m_q;
  logic [47:0]    b_cw_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_sd_q <= a_sd_q;
      b_k_q  <= 49'(a_fs_q) * 49'(a_t_q);
      b_m_q  <= 48'(a_fn_q) * 48'(a_s_q);
      b_cw_q <= a_cw_q;
    end
  end

  // stage C: W times k and m, as 32-bit halves
  ssb_pkg::side_t c_sd_q;
  logic [63:0]    c_kl_q, c_ml_q;
  logic [48:0]    c_kh_q;
  logic [47:0]    c_mh_q;
  logic [47:0]    c_cw_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_sd_q <= b_sd_q;
      c_kl_q <= 64'(b_sd_q.w) * 64'(b_k_q[31:0]);
      c_kh_q <= 49'(b_sd_q.w) * 49'(b_k_q[48:32]);
      c_ml_q <= 64'(b_sd_q.w) * 64'(b_m_q[31:0]);
      c_mh_q <= 48'(b_sd_q.w) * 48'(b_m_q[47:32]);
      c_cw_q <= b_cw_q;
    end
  end

  // stage D: slope + constant sum, normal offset finished
  logic [80:0] wk_d;
  logic [79:0] wm_d;
  logic [57:0] sum_d;
  logic [31:0] nrm_d;
  ssb_pkg::side_t d_sd_q;
  logic [57:0]    d_sum_q;
  logic [31:0]    d_nrm_q;

  always_comb begin
    wk_d  = {c_kh_q, 32'd0} + 81'(c_kl_q);
    wm_d  = {c_mh_q, 32'd0} + 80'(c_ml_q);
    sum_d = 58'(wk_d[80:24]) + 58'(c_cw_q[47:8]);
    nrm_d = (|wm_d[79:62]) ? 32'hFFFF_FFFF : wm_d[61:30];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_sd_q  <= c_sd_q;
      d_sum_q <= sum_d;
      d_nrm_q <= nrm_d;
    end
  end

  // stage E: sum times D, as 32-bit halves
  logic [63:0] e_pl_q;
  logic [57:0] e_ph_q;
  logic [31:0] e_nrm_q;
  logic        e_z_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_pl_q  <= 64'(d_sum_q[31:0]) * 64'(d_sd_q.d);
      e_ph_q  <= 58'(d_sum_q[57:32]) * 58'(d_sd_q.d);
      e_nrm_q <= d_nrm_q;
      e_z_q   <= d_sd_q.z;
    end
  end

  // stage F: combine, saturate, zero-scale override
  logic [89:0] pd_d;
  logic [31:0] rcv_d;
  logic [31:0] rcv_q, nrm_q;

  always_comb begin
    pd_d  = {e_ph_q, 32'd0} + 90'(e_pl_q);
    rcv_d = (|pd_d[89:48]) ? 32'hFFFF_FFFF : pd_d[47:16];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rcv_q <= e_z_q ? 32'd0 : rcv_d;
      nrm_q <= e_z_q ? 32'd0 : e_nrm_q;
    end
  end

  assign receiver_depth_bias_o = rcv_q;
  assign normal_offset_world_o = nrm_q;

endmodule

/* rtl/slope_scaled_shadow_bias.sv */
// ----------------------------------------------------------------------------
// slope_scaled_shadow_bias
// Per-fragment receiver depth bias and world-space normal offset.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one fragment: cosine, texel
// size, depth scale and filter radius. Output channel (out_valid_o/
// out_ready_i) returns one result per fragment, in order.
// The pipeline has one clamp/square stage, four square-root stages, four
// divider stages and six multiply/saturate stages. One fragment is
// accepted every cycle while no finished result is held; the 15-stage
// pipeline advances as a whole.
// When the receiver stalls with a result waiting, every stage holds and
// in_ready_o drops; bubbles inside the pipeline hold as well.
// Reset empties the pipeline and restores the register defaults
// (slope gain 1.0, tangent clamp 10.0, other gains 0).
// Config writes through cfg_we_i/cfg_idx_i/cfg_data_i take effect at once
// and are expected only while the pipeline is empty.
// ----------------------------------------------------------------------------
`include "slope_scaled_shadow_bias_defines.svh"

module slope_scaled_shadow_bias (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] n_dot_l_i,
  input  logic [31:0]        world_per_texel_i,
  input  logic [31:0]        depth_per_world_i,
  input  logic [15:0]        filter_radius_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        receiver_depth_bias_o,
  output logic [31:0]        normal_offset_world_o
);

  localparam int unsigned Last = ssb_pkg::NumStages - 1;

  ssb_pkg::cfg_t  cfg_q;
  ssb_pkg::side_t side;
  ssb_pkg::sq_t   sq;
  ssb_pkg::dv_t   dv;
  logic [ssb_pkg::NumStages-1:0] vld_q;
  logic en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slope_scale   <= ssb_pkg::SlopeScaleRst;
      cfg_q.const_texels  <= ssb_pkg::ConstTexelsRst;
      cfg_q.normal_texels <= ssb_pkg::NormalTexelsRst;
      cfg_q.max_tangent   <= ssb_pkg::MaxTangentRst;
    end else if (cfg_we_i) begin
      case (ssb_pkg::cfg_idx_e'(cfg_idx_i))
        ssb_pkg::REG_SLOPE_SCALE:   cfg_q.slope_scale   <= cfg_data_i;
        ssb_pkg::REG_CONST_TEXELS:  cfg_q.const_texels  <= cfg_data_i;
        ssb_pkg::REG_NORMAL_TEXELS: cfg_q.normal_texels <= cfg_data_i;
        ssb_pkg::REG_MAX_TANGENT:   cfg_q.max_tangent   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless a finished result is held
  assign en          = !vld_q[Last] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[Last];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Last-1:0], in_valid_i};
    end
  end

  always_comb begin
    side.w = world_per_texel_i;
    side.d = depth_per_world_i;
    side.f = 17'(filter_radius_i) + 17'd256;
    side.z = (world_per_texel_i == 32'd0) || (depth_per_world_i == 32'd0);
  end

  ssb_sqrt u_sqrt (
    .clk_i     (clk_i),
    .en_i      (en),
    .n_dot_l_i (n_dot_l_i),
    .side_i    (side),
    .sq_o      (sq)
  );

  ssb_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .sq_i  (sq),
    .dv_o  (dv)
  );

  ssb_mul u_mul (
    .clk_i                 (clk_i),
    .en_i                  (en),
    .dv_i                  (dv),
    .cfg_i                 (cfg_q),
    .receiver_depth_bias_o (receiver_depth_bias_o),
    .normal_offset_world_o (normal_offset_world_o)
  );

  `SSB_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_q), "valid chain moved during stall")
  `SSB_ASSERT_NEXT(a_enter, in_valid_i && in_ready_o, vld_q[0], "accepted transaction lost")
  `SSB_ASSERT_IMPL(a_out_src, out_valid_o, $past(vld_q[Last-1]) || $past(out_valid_o),
                   "result appeared without a predecessor")

endmodule

/* tb/slope_scaled_shadow_bias_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slope-scaled shadow bias testbench
// Drives fragments through the valid/ready input channel and checks every
// depth bias and normal offset against a bit-exact fixed-point predictor.
// Covers swept register settings, the cosine clamp cases and the zero scales,
// with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module slope_scaled_shadow_bias_tb;

  localparam int unsigned PipeDepth = ssb_pkg::NumStages;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic [31:0] bias;
    logic [31:0] offset;
  } bias_pair_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [15:0] n_dot_l_i;
  logic [31:0]        world_per_texel_i;
  logic [31:0]        depth_per_world_i;
  logic [15:0]        filter_radius_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [31:0]        receiver_depth_bias_o;
  logic [31:0]        normal_offset_world_o;

  ssb_pkg::cfg_t regs;
  bias_pair_t    bias_q[$];
  int            errors;
  int            idle_cycles;
  bit            hold_off;
  bit            rx_busy;

  slope_scaled_shadow_bias DUT (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // floor(a*b / 2^sh), saturated to 64 bits
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic logic [14:0] root_floor(logic [28:0] v);
    logic [14:0] r;
    r = '0;
    for (int b = 14; b >= 0; b--) begin
      r[b] = 1'b1;
      if ((32'(r) * 32'(r)) > 32'(v)) r[b] = 1'b0;
    end
    return r;
  endfunction

  function automatic bias_pair_t predict_bias(logic [15:0] raw, logic [31:0] w,
                                              logic [31:0] d, logic [15:0] rad);
    bias_pair_t  res;
    logic [14:0] c;
    logic [14:0] s;
    logic [31:0] q;
    logic [15:0] t;
    logic [16:0] f;
    logic [63:0] k, m, slope_w, const_w, sum, bias;
    logic [64:0] wide;
    res = '0;
    if (w == 0 || d == 0) return res;
    if (raw[15]) c = 15'd0;
    else c = (raw > 16'd16384) ? 15'd16384 : raw[14:0];
    s = root_floor(29'(32'd1 << 28) - 29'(c * c));
    if (c == 0) begin
      t = regs.max_tangent;
    end else begin
      q = {9'd0, s, 8'd0} / c;
      t = (q < regs.max_tangent) ? q[15:0] : regs.max_tangent;
    end
    f = {1'b0, rad} + 17'd256;
    k = 64'(f) * 64'(regs.slope_scale) * 64'(t);
    slope_w = mul_shift(64'(w), k, 24);
    const_w = mul_shift(64'(w), 64'(regs.const_texels), 8);
    wide = {1'b0, slope_w} + {1'b0, const_w};
    sum = wide[64] ? '1 : wide[63:0];
    bias = mul_shift(sum, 64'(d), 16);
    res.bias = (bias > 64'hFFFF_FFFF) ? '1 : bias[31:0];
    m = 64'(f) * 64'(regs.normal_texels) * 64'(s);
    bias = mul_shift(64'(w), m, 30);
    res.offset = (bias > 64'hFFFF_FFFF) ? '1 : bias[31:0];
    return res;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(ssb_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      ssb_pkg::REG_SLOPE_SCALE:   regs.slope_scale = val;
      ssb_pkg::REG_CONST_TEXELS:  regs.const_texels = val;
      ssb_pkg::REG_NORMAL_TEXELS: regs.normal_texels = val;
      ssb_pkg::REG_MAX_TANGENT:   regs.max_tangent = val;
      default: ;
    endcase
  endtask

  task automatic apply_regs(logic [15:0] ss, logic [15:0] ct, logic [15:0] nt,
                            logic [15:0] mt);
    while (bias_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
    write_reg(ssb_pkg::REG_SLOPE_SCALE, ss);
    write_reg(ssb_pkg::REG_CONST_TEXELS, ct);
    write_reg(ssb_pkg::REG_NORMAL_TEXELS, nt);
    write_reg(ssb_pkg::REG_MAX_TANGENT, mt);
    cfg_we_i <= 1'b0;
  endtask

  // one fragment; gap may be skipped so valid stays high back to back
  task automatic send_fragment(logic [15:0] ndl, logic [31:0] w, logic [31:0] d,
                               logic [15:0] rad, bit idle_ok);
    int gap;
    gap = idle_ok ? gap_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    n_dot_l_i         <= ndl;
    world_per_texel_i <= w;
    depth_per_world_i <= d;
    filter_radius_i   <= rad;
    do @(posedge clk_i); while (!in_ready_o);
    bias_q.push_back(predict_bias(ndl, w, d, rad));
  endtask

  task automatic send_random(int n, bit idle_ok);
    logic [15:0] ndl;
    logic [31:0] w, d;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: ndl = 16'($urandom());
        1: ndl = 16'($urandom_range(16384, 32767));
        default: ndl = 16'($urandom_range(0, 16384));
      endcase
      w = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0004_0000);
      d = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0001_0000);
      if ($urandom_range(0, 40) == 0) w = 0;
      if ($urandom_range(0, 40) == 0) d = 0;
      send_fragment(ndl, w, d, 16'($urandom()), idle_ok);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    logic [15:0] cos_set[8] = '{16'h0000, 16'h4000, 16'h8000, 16'h7FFF, 16'hFFFF,
                                16'h2D41, 16'h0001, 16'h3FFF};
    foreach (cos_set[i])
      send_fragment(cos_set[i], 32'h0001_0000, 32'h0001_0000, 16'h0100, 1'b0);
    send_fragment(16'h2000, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_fragment(16'h2000, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 1'b0);
    send_fragment(16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_fragment(16'h2000, 32'd1, 32'd1, 16'h0000, 1'b0);
    send_fragment(16'hC000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 1'b0);
    in_valid_i <= 1'b0;
  endtask

  task automatic test_register_sweep();
    apply_regs(16'h0100, 16'h0080, 16'h0100, 16'h0A00);
    test_directed();
    apply_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_directed();
    apply_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_random(150, 1'b1);
    for (int p = 0; p < 6; p++) begin
      apply_regs(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
      send_random(200, p[0]);
    end
  endtask

  task automatic test_output_stall();
    @(posedge clk_i);
    hold_off = 1'b1;
    send_random(60, 1'b0);
    hold_off = 1'b0;
  endtask

  // receiver: random ready, one long hold-off on request
  always @(posedge clk_i) begin
    if (!rx_busy) begin
      rx_busy = 1'b1;
      fork
        begin
          if (hold_off) begin
            out_ready_i <= 1'b0;
            hold_off = 1'b0;
            repeat (300) @(posedge clk_i);
          end else if ($urandom_range(0, 2) == 0) begin
            out_ready_i <= 1'b0;
            repeat (gap_len() + 1) @(posedge clk_i);
          end else begin
            out_ready_i <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk_i);
          end
          rx_busy = 1'b0;
        end
      join_none
    end
  end

  always @(posedge clk_i) begin
    bias_pair_t exp_v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bias_q.size() == 0) begin
        $display("%0t: unexpected result %h %h", $time, receiver_depth_bias_o,
                 normal_offset_world_o);
        errors++;
      end else begin
        exp_v = bias_q.pop_front();
        if (receiver_depth_bias_o !== exp_v.bias) begin
          $display("%0t: receiver_depth_bias expected %h actual %h", $time,
                   exp_v.bias, receiver_depth_bias_o);
          errors++;
        end
        if (normal_offset_world_o !== exp_v.offset) begin
          $display("%0t: normal_offset_world expected %h actual %h", $time,
                   exp_v.offset, normal_offset_world_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    rx_busy = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ssb_pkg::REG_SLOPE_SCALE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    n_dot_l_i = '0;
    world_per_texel_i = '0;
    depth_per_world_i = '0;
    filter_radius_i = '0;
    regs = '{slope_scale: ssb_pkg::SlopeScaleRst, const_texels: ssb_pkg::ConstTexelsRst,
             normal_texels: ssb_pkg::NormalTexelsRst,
             max_tangent: ssb_pkg::MaxTangentRst};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_output_stall();
    test_register_sweep();
    while (bias_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 5) @(posedge clk_i);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

/* slope_scaled_shadow_bias.f */
+incdir+rtl
rtl/ssb_pkg.sv
rtl/ssb_sqrt.sv
rtl/ssb_div.sv
rtl/ssb_mul.sv
rtl/slope_scaled_shadow_bias.sv
tb/slope_scaled_shadow_bias_tb.sv
